// File: hw/rtl/stsc_pkg.sv
// ----------------------------------------------------------------------------
// Source token scanner package
// Token kinds, scanner modes, record types and the keyword table.
// ----------------------------------------------------------------------------
package stsc_pkg;

    localparam int KIND_W = 6;
    localparam int POS_OUT_W = 24;
    localparam int LEN_W = 24;
    localparam int INT_W = 31;

    localparam logic [LEN_W-1:0] LEN_MAX = '1;
    localparam logic [INT_W-1:0] INT_MAX = '1;

    localparam logic [KIND_W-1:0] K_DOT       = 6'd0;
    localparam logic [KIND_W-1:0] K_COMMA     = 6'd1;
    localparam logic [KIND_W-1:0] K_SEMI      = 6'd2;
    localparam logic [KIND_W-1:0] K_COLON     = 6'd3;
    localparam logic [KIND_W-1:0] K_PLUS      = 6'd4;
    localparam logic [KIND_W-1:0] K_MINUS     = 6'd5;
    localparam logic [KIND_W-1:0] K_STAR      = 6'd6;
    localparam logic [KIND_W-1:0] K_HASH      = 6'd7;
    localparam logic [KIND_W-1:0] K_SLASH     = 6'd8;
    localparam logic [KIND_W-1:0] K_EQ_EQ     = 6'd9;
    localparam logic [KIND_W-1:0] K_ASSIGN    = 6'd10;
    localparam logic [KIND_W-1:0] K_NOT_EQ    = 6'd11;
    localparam logic [KIND_W-1:0] K_NOT       = 6'd12;
    localparam logic [KIND_W-1:0] K_LESS_EQ   = 6'd13;
    localparam logic [KIND_W-1:0] K_LESS      = 6'd14;
    localparam logic [KIND_W-1:0] K_GREATER_EQ = 6'd15;
    localparam logic [KIND_W-1:0] K_GREATER   = 6'd16;
    localparam logic [KIND_W-1:0] K_LPAREN    = 6'd17;
    localparam logic [KIND_W-1:0] K_RPAREN    = 6'd18;
    localparam logic [KIND_W-1:0] K_LBRACE    = 6'd19;
    localparam logic [KIND_W-1:0] K_RBRACE    = 6'd20;
    localparam logic [KIND_W-1:0] K_LBRACKET  = 6'd21;
    localparam logic [KIND_W-1:0] K_RBRACKET  = 6'd22;
    localparam logic [KIND_W-1:0] K_STRING    = 6'd23;
    localparam logic [KIND_W-1:0] K_INTEGER   = 6'd24;
    localparam logic [KIND_W-1:0] K_IDENT     = 6'd25;
    localparam logic [KIND_W-1:0] K_KEYWORD0  = 6'd26;
    localparam logic [KIND_W-1:0] K_EOF       = 6'd34;

    typedef enum logic [2:0] {
        M_IDLE,
        M_OP,
        M_SLASH,
        M_COMMENT,
        M_STRING,
        M_NUMBER,
        M_WORD,
        M_DONE
    } scan_mode_t;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [POS_OUT_W-1:0] start_pos;
        logic [LEN_W-1:0]     lexeme_len;
        logic [INT_W-1:0]     int_value;
        logic                 string_error;
        logic                 last;
    } token_t;

    typedef struct packed {
        token_t tok0;
        token_t tok1;
        logic   pair;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = 2;

    localparam int NUM_KW = 8;
    localparam int KW_TEXT_LEN = 10;

    // Keywords are right-justified: the first character sits in the highest used byte.
    localparam logic [8*KW_TEXT_LEN-1:0] KW_TEXT [NUM_KW] = '{
        80'("escreveR"), 80'("var"), 80'("verdadeiro"), 80'("falso"),
        80'("enquanto"), 80'("se"), 80'("senao"), 80'("fim")
    };
    localparam int KW_LEN [NUM_KW] = '{8, 3, 10, 5, 8, 2, 5, 3};

    function automatic logic is_decimal(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_word_char(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) ||
               (c == "_") || is_decimal(c);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h0D) || (c == 8'h0A) || (c == 8'h09);
    endfunction

    function automatic logic is_newline(input logic [7:0] c);
        return (c == 8'h0D) || (c == 8'h0A);
    endfunction

    // Returns {hit, kind} for the single-character punctuation set.
    function automatic logic [KIND_W:0] punct_lookup(input logic [7:0] c);
        logic [KIND_W:0] r;
        case (c)
            ".":     r = {1'b1, K_DOT};
            ",":     r = {1'b1, K_COMMA};
            ";":     r = {1'b1, K_SEMI};
            ":":     r = {1'b1, K_COLON};
            "+":     r = {1'b1, K_PLUS};
            "-":     r = {1'b1, K_MINUS};
            "*":     r = {1'b1, K_STAR};
            "#":     r = {1'b1, K_HASH};
            "(":     r = {1'b1, K_LPAREN};
            ")":     r = {1'b1, K_RPAREN};
            "{":     r = {1'b1, K_LBRACE};
            "}":     r = {1'b1, K_RBRACE};
            "[":     r = {1'b1, K_LBRACKET};
            "]":     r = {1'b1, K_RBRACKET};
            default: r = {1'b0, K_DOT};
        endcase
        return r;
    endfunction

    function automatic logic [KIND_W-1:0] pair_kind(input logic [KIND_W-1:0] k);
        logic [KIND_W-1:0] r;
        case (k)
            K_ASSIGN:  r = K_EQ_EQ;
            K_NOT:     r = K_NOT_EQ;
            K_LESS:    r = K_LESS_EQ;
            default:   r = K_GREATER_EQ;
        endcase
        return r;
    endfunction

endpackage

// File: hw/rtl/stsc_in_if.sv
// ----------------------------------------------------------------------------
// Scanner input channel
// Carries one source byte or the end marker per beat.
// ----------------------------------------------------------------------------
interface stsc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       end_of_source;

    modport source (output valid, output ch, output end_of_source, input ready);
    modport sink (input valid, input ch, input end_of_source, output ready);
endinterface

// File: hw/rtl/stsc_out_if.sv
// ----------------------------------------------------------------------------
// Scanner token channel
// Carries one token record per beat.
// ----------------------------------------------------------------------------
interface stsc_out_if;
    logic                           valid;
    logic                           ready;
    logic [stsc_pkg::KIND_W-1:0]    kind;
    logic [stsc_pkg::POS_OUT_W-1:0] start_pos;
    logic [stsc_pkg::LEN_W-1:0]     lexeme_len;
    logic [stsc_pkg::INT_W-1:0]     int_value;
    logic                           string_error;
    logic                           last;

    modport source (output valid, output kind, output start_pos, output lexeme_len,
                     output int_value, output string_error, output last, input ready);
    modport sink (input valid, input kind, input start_pos, input lexeme_len,
                  input int_value, input string_error, input last, output ready);
endinterface

// File: hw/rtl/stsc_front.sv
// ----------------------------------------------------------------------------
// Scanner front end
// Classifies each accepted byte, tracks the token in progress and builds
// the one or two token records that the byte completes.
// ----------------------------------------------------------------------------
module stsc_front #(
    parameter int POS_BITS = 24,
    parameter int KEYWORD_MAX_LEN = 10
) (
    input  logic                clk,
    input  logic                rst_n,
    stsc_in_if.sink             in,
    output logic                push_valid,
    output stsc_pkg::entry_t    push_entry,
    input  stsc_pkg::q_status_t q_status
);
    import stsc_pkg::*;

    localparam int IDX_W = $clog2(KEYWORD_MAX_LEN);
    localparam int EXT_W = (POS_BITS > POS_OUT_W) ? POS_BITS : POS_OUT_W;
    localparam int ACC_W = INT_W + 4;

    scan_mode_t          mode_reg, mode_next;
    logic [KIND_W-1:0]   pend_kind_reg, pend_kind_next;
    logic [POS_BITS-1:0] tstart_reg, tstart_next;
    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [INT_W-1:0]    acc_reg, acc_next;
    logic [7:0]          word_chars [KEYWORD_MAX_LEN];

    logic             accept;
    logic [7:0]       c;
    logic             at_end;
    logic             cont;
    logic [POS_BITS-1:0] pos_inc;
    logic [LEN_W-1:0] len_inc;
    logic [ACC_W-1:0] acc_prod;
    logic [INT_W-1:0] acc_sat;
    logic [KIND_W:0]  punct;
    logic [KIND_W-1:0] word_kind;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic             flush_valid, new_valid;
    token_t           flush_tok, new_tok;

    function automatic logic [POS_OUT_W-1:0] sat_pos(input logic [POS_BITS-1:0] p);
        logic [EXT_W-1:0] e;
        e = EXT_W'(p);
        return (e > EXT_W'(LEN_MAX)) ? LEN_MAX : e[POS_OUT_W-1:0];
    endfunction

    assign in.ready = !q_status.full;
    assign accept = in.valid && in.ready;
    assign c = in.ch;
    assign at_end = in.end_of_source || (in.ch == 8'h00);

    assign pos_inc = (pos_reg != '1) ? pos_reg + POS_BITS'(1) : pos_reg;
    assign len_inc = (len_reg != LEN_MAX) ? len_reg + LEN_W'(1) : len_reg;
    assign acc_prod = (ACC_W'(acc_reg) << 3) + (ACC_W'(acc_reg) << 1) + ACC_W'(c[3:0]);
    assign acc_sat = (acc_prod > ACC_W'(INT_MAX)) ? INT_MAX : acc_prod[INT_W-1:0];
    assign punct = punct_lookup(c);

    always_comb
    begin
        logic hit;
        word_kind = K_IDENT;
        for (int i = NUM_KW - 1; i >= 0; i--)
        begin
            hit = (len_reg == LEN_W'(KW_LEN[i]));
            for (int j = 0; j < KW_TEXT_LEN; j++)
            begin
                if (j < KW_LEN[i])
                begin
                    if (word_chars[j] != KW_TEXT[i][8*(KW_LEN[i]-1-j) +: 8])
                    begin
                        hit = 1'b0;
                    end
                end
            end
            if (hit)
            begin
                word_kind = K_KEYWORD0 + KIND_W'(i);
            end
        end
    end

    always_comb
    begin
        case (mode_reg)
            M_DONE:    cont = 1'b1;
            M_OP:      cont = !at_end && (c == "=");
            M_SLASH:   cont = !at_end && (c == "/");
            M_COMMENT: cont = !at_end && !is_newline(c);
            M_STRING:  cont = !at_end;
            M_NUMBER:  cont = !at_end && is_decimal(c);
            M_WORD:    cont = !at_end && is_word_char(c);
            default:   cont = 1'b0;
        endcase
    end

    always_comb
    begin
        mode_next = mode_reg;
        if (mode_reg == M_DONE)
        begin
            mode_next = M_DONE;
        end
        else if (cont)
        begin
            case (mode_reg)
                M_OP:     mode_next = M_IDLE;
                M_SLASH:  mode_next = M_COMMENT;
                M_STRING: mode_next = (c == "\"") ? M_IDLE : M_STRING;
                default:  mode_next = mode_reg;
            endcase
        end
        else if (at_end)
        begin
            mode_next = M_DONE;
        end
        else if (punct[KIND_W] || is_space(c))
        begin
            mode_next = M_IDLE;
        end
        else if ((c == "=") || (c == "!") || (c == "<") || (c == ">"))
        begin
            mode_next = M_OP;
        end
        else if (c == "/")
        begin
            mode_next = M_SLASH;
        end
        else if (c == "\"")
        begin
            mode_next = M_STRING;
        end
        else if (is_decimal(c))
        begin
            mode_next = M_NUMBER;
        end
        else
        begin
            mode_next = M_WORD;
        end
    end

    always_comb
    begin
        pend_kind_next = pend_kind_reg;
        tstart_next = tstart_reg;
        pos_next = pos_reg;
        len_next = len_reg;
        acc_next = acc_reg;
        wr_en = 1'b0;
        wr_idx = len_reg[IDX_W-1:0];
        flush_valid = 1'b0;
        new_valid = 1'b0;
        flush_tok = '0;
        flush_tok.start_pos = sat_pos(tstart_reg);
        flush_tok.lexeme_len = len_reg;
        new_tok = '0;
        new_tok.start_pos = sat_pos(pos_reg);
        if (mode_reg != M_DONE)
        begin
            if (cont)
            begin
                pos_next = pos_inc;
                case (mode_reg)
                    M_OP:
                    begin
                        flush_valid = 1'b1;
                        flush_tok.kind = pair_kind(pend_kind_reg);
                        flush_tok.lexeme_len = LEN_W'(2);
                    end
                    M_STRING:
                    begin
                        len_next = len_inc;
                        flush_valid = (c == "\"");
                        flush_tok.kind = K_STRING;
                        flush_tok.lexeme_len = len_inc;
                    end
                    M_NUMBER:
                    begin
                        acc_next = acc_sat;
                        len_next = len_inc;
                    end
                    M_WORD:
                    begin
                        wr_en = (len_reg < LEN_W'(KEYWORD_MAX_LEN));
                        len_next = len_inc;
                    end
                    default:
                    begin
                        pos_next = pos_inc;
                    end
                endcase
            end
            else
            begin
                case (mode_reg)
                    M_OP:
                    begin
                        flush_valid = 1'b1;
                        flush_tok.kind = pend_kind_reg;
                        flush_tok.lexeme_len = LEN_W'(1);
                    end
                    M_SLASH:
                    begin
                        flush_valid = 1'b1;
                        flush_tok.kind = K_SLASH;
                        flush_tok.lexeme_len = LEN_W'(1);
                    end
                    M_STRING:
                    begin
                        flush_valid = 1'b1;
                        flush_tok.kind = K_STRING;
                        flush_tok.string_error = 1'b1;
                    end
                    M_NUMBER:
                    begin
                        flush_valid = 1'b1;
                        flush_tok.kind = K_INTEGER;
                        flush_tok.int_value = acc_reg;
                    end
                    M_WORD:
                    begin
                        flush_valid = 1'b1;
                        flush_tok.kind = word_kind;
                    end
                    default:
                    begin
                        flush_valid = 1'b0;
                    end
                endcase
                tstart_next = pos_reg;
                if (at_end)
                begin
                    new_valid = 1'b1;
                    new_tok.kind = K_EOF;
                    new_tok.last = 1'b1;
                end
                else
                begin
                    pos_next = pos_inc;
                    len_next = LEN_W'(1);
                    new_tok.kind = punct[KIND_W-1:0];
                    new_tok.lexeme_len = LEN_W'(1);
                    new_valid = punct[KIND_W];
                    case (c)
                        "=":     pend_kind_next = K_ASSIGN;
                        "!":     pend_kind_next = K_NOT;
                        "<":     pend_kind_next = K_LESS;
                        ">":     pend_kind_next = K_GREATER;
                        default: pend_kind_next = pend_kind_reg;
                    endcase
                    acc_next = INT_W'(c[3:0]);
                    wr_en = !punct[KIND_W] && !is_space(c) && !is_decimal(c) &&
                            (c != "=") && (c != "!") && (c != "<") && (c != ">") &&
                            (c != "/") && (c != "\"");
                    wr_idx = '0;
                end
            end
        end
    end

    always_comb
    begin
        push_entry.pair = flush_valid && new_valid;
        push_entry.tok0 = flush_valid ? flush_tok : new_tok;
        push_entry.tok1 = new_tok;
        push_valid = accept && (flush_valid || new_valid);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            pend_kind_reg <= '0;
            tstart_reg <= '0;
            pos_reg <= '0;
            len_reg <= '0;
            acc_reg <= '0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            pend_kind_reg <= pend_kind_next;
            tstart_reg <= tstart_next;
            pos_reg <= pos_next;
            len_reg <= len_next;
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && wr_en)
        begin
            word_chars[wr_idx] <= c;
        end
    end

endmodule

// File: hw/rtl/stsc_queue.sv
// ----------------------------------------------------------------------------
// Scanner record queue
// Short first-in first-out store of token records between the two ends.
// ----------------------------------------------------------------------------
module stsc_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  stsc_pkg::entry_t     push_entry,
    input  logic                 pop,
    output stsc_pkg::entry_t     head_entry,
    output stsc_pkg::q_status_t  q_status
);
    import stsc_pkg::*;

    entry_t            slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;

    assign q_status.full = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign head_entry = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next = count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// File: hw/rtl/stsc_back.sv
// ----------------------------------------------------------------------------
// Scanner back end
// Takes queued records and hands them out one token per beat.
// ----------------------------------------------------------------------------
module stsc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  stsc_pkg::entry_t    head_entry,
    input  stsc_pkg::q_status_t q_status,
    output logic                pop,
    stsc_out_if.source          out
);
    import stsc_pkg::*;

    logic   sel_reg, sel_next;
    logic   out_accept;
    token_t tok;

    assign tok = sel_reg ? head_entry.tok1 : head_entry.tok0;
    assign out.valid = !q_status.empty;
    assign out.kind = tok.kind;
    assign out.start_pos = tok.start_pos;
    assign out.lexeme_len = tok.lexeme_len;
    assign out.int_value = tok.int_value;
    assign out.string_error = tok.string_error;
    assign out.last = tok.last;

    assign out_accept = out.valid && out.ready;
    assign pop = out_accept && (sel_reg || !head_entry.pair);

    always_comb
    begin
        sel_next = sel_reg;
        if (out_accept)
        begin
            sel_next = !pop;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg <= 1'b0;
        end
        else
        begin
            sel_reg <= sel_next;
        end
    end

endmodule

// File: hw/rtl/source_token_scanner_core.sv
// ----------------------------------------------------------------------------
// Source token scanner
// Streaming lexer: source bytes in, token records out.
//
// The in channel takes one source byte per beat, or an end marker; a zero
// byte also ends the source. The out channel gives one token record per
// beat: kind, start position, length, integer value, string error flag and
// a last flag on the closing EOF token.
// A byte is taken every cycle while the record queue has room. The front
// end resolves each byte in the cycle it is taken and writes the one or two
// records it completes into a four-entry queue, whose registered head
// is offered on out. A byte that completes two records
// occupies the out channel for two beats, so sustained throughput is one
// byte per cycle until the out side falls behind. When the receiver stalls
// the queue fills and in.ready drops; no record is lost. Tokens that need a
// look-ahead byte are completed by the following byte or by the end.
// Reset clears the scanner state and empties the queue. After EOF, further
// bytes are taken and ignored until the next reset.
// ----------------------------------------------------------------------------
module source_token_scanner_core #(
    parameter int POS_BITS = 24,
    parameter int KEYWORD_MAX_LEN = 10
) (
    input  logic       clk,
    input  logic       rst_n,
    stsc_in_if.sink    in,
    stsc_out_if.source out
);
    import stsc_pkg::*;

    logic      push_valid;
    entry_t    push_entry;
    entry_t    head_entry;
    q_status_t q_status;
    logic      pop;

    stsc_front #(
        .POS_BITS        (POS_BITS),
        .KEYWORD_MAX_LEN (KEYWORD_MAX_LEN)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in         (in),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .q_status   (q_status)
    );

    stsc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push_valid),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .q_status   (q_status)
    );

    stsc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_entry (head_entry),
        .q_status   (q_status),
        .pop        (pop),
        .out        (out)
    );

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> !q_status.full)
        else $error("record written into a full queue");

    a_eof_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        (out.valid && out.ready && out.last) |=> !out.valid)
        else $error("token delivered after EOF");

    a_eof_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out.valid && out.last) |-> (out.kind == K_EOF && out.lexeme_len == '0))
        else $error("last beat is not an empty EOF token");

    a_error_on_string: assert property (@(posedge clk) disable iff (!rst_n)
        (out.valid && out.string_error) |-> (out.kind == K_STRING))
        else $error("string error flag on a non-string token");

endmodule

// File: tb/source_token_scanner_checker.sv
// ----------------------------------------------------------------------------
// Source token scanner checker
// Watches both channels of the scanner. Every byte beat taken on the input is
// run through an independent model of the lexer, which queues the token
// records it should produce; every record beat on the output is compared
// field by field with the oldest queued record. The number of failures and
// the number of records still awaited are handed to the testbench top.
// ----------------------------------------------------------------------------
module source_token_scanner_checker #(
    parameter int POS_BITS = 24,
    parameter int WORD_MAX = 10
) (
    input  logic clk,
    input  logic rst_n,
    stsc_in_if   src,
    stsc_out_if  tok,
    output int   mismatches,
    output int   outstanding
);
    import stsc_pkg::*;

    localparam int BUF_IDX_W = $clog2(WORD_MAX);

    localparam logic [7:0] NUL   = 8'h00;
    localparam logic [7:0] TAB   = 8'h09;
    localparam logic [7:0] LF    = 8'h0A;
    localparam logic [7:0] CR    = 8'h0D;
    localparam logic [7:0] QUOTE = 8'h22;

    scan_mode_t          mode;
    logic [KIND_W-1:0]   held_kind;
    logic [KIND_W-1:0]   held_pair;
    logic [POS_BITS-1:0] token_origin;
    logic [POS_BITS-1:0] position;
    logic [7:0]          word_buf [WORD_MAX];
    logic [INT_W-1:0]    value_acc;
    logic [LEN_W-1:0]    run_len;
    token_t              expected_tokens [$];
    string               keywords [NUM_KW] = '{"escreveR", "var", "verdadeiro", "falso",
                                               "enquanto", "se", "senao", "fim"};

    function automatic logic is_numeral(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic continues_word(input logic [7:0] c);
        return is_numeral(c) || c == "_" || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic [KIND_W-1:0] word_kind();
        logic [KIND_W-1:0] k;
        logic              same;
        k = K_IDENT;
        if (run_len <= LEN_W'(WORD_MAX)) begin
            for (int i = 0; i < NUM_KW; i++) begin
                if (keywords[i].len() == int'(run_len)) begin
                    same = 1'b1;
                    for (int j = 0; j < keywords[i].len(); j++)
                        if (word_buf[j] != keywords[i][j])
                            same = 1'b0;
                    if (same)
                        k = K_KEYWORD0 + KIND_W'(i);
                end
            end
        end
        return k;
    endfunction

    task automatic expect_token(input logic [KIND_W-1:0] k, input logic [LEN_W-1:0] len,
                                input logic [INT_W-1:0] value, input logic err,
                                input logic closing);
        token_t t;
        t.kind = k;
        if (64'(token_origin) > 64'(LEN_MAX))
            t.start_pos = LEN_MAX;
        else
            t.start_pos = POS_OUT_W'(token_origin);
        t.lexeme_len = len;
        t.int_value = value;
        t.string_error = err;
        t.last = closing;
        expected_tokens.push_back(t);
    endtask

    task automatic step_position();
        if (position != '1)
            position++;
    endtask

    task automatic grow_run();
        if (run_len != LEN_MAX)
            run_len++;
    endtask

    task automatic scan_byte(input logic [7:0] c, input logic eos);
        logic              at_end;
        logic              is_punct;
        logic [KIND_W-1:0] k;
        logic [63:0]       wide;
        at_end = eos || (c == NUL);
        case (mode)
            M_DONE:
                return;
            M_OP:
            begin
                mode = M_IDLE;
                if (!at_end && c == "=")
                begin
                    expect_token(held_pair, LEN_W'(2), INT_W'(0), 1'b0, 1'b0);
                    step_position();
                    return;
                end
                expect_token(held_kind, LEN_W'(1), INT_W'(0), 1'b0, 1'b0);
            end
            M_SLASH:
            begin
                if (!at_end && c == "/")
                begin
                    mode = M_COMMENT;
                    step_position();
                    return;
                end
                mode = M_IDLE;
                expect_token(K_SLASH, LEN_W'(1), INT_W'(0), 1'b0, 1'b0);
            end
            M_COMMENT:
            begin
                if (!at_end && c != LF && c != CR)
                begin
                    step_position();
                    return;
                end
                mode = M_IDLE;
            end
            M_STRING:
            begin
                if (at_end)
                begin
                    mode = M_IDLE;
                    expect_token(K_STRING, run_len, INT_W'(0), 1'b1, 1'b0);
                end
                else
                begin
                    grow_run();
                    step_position();
                    if (c == QUOTE)
                    begin
                        mode = M_IDLE;
                        expect_token(K_STRING, run_len, INT_W'(0), 1'b0, 1'b0);
                    end
                    return;
                end
            end
            M_NUMBER:
            begin
                if (!at_end && is_numeral(c))
                begin
                    wide = 64'(value_acc) * 64'd10 + (64'(c) - 64'("0"));
                    value_acc = (wide > 64'(INT_MAX)) ? INT_MAX : wide[INT_W-1:0];
                    grow_run();
                    step_position();
                    return;
                end
                mode = M_IDLE;
                expect_token(K_INTEGER, run_len, value_acc, 1'b0, 1'b0);
            end
            M_WORD:
            begin
                if (!at_end && continues_word(c))
                begin
                    if (run_len < LEN_W'(WORD_MAX))
                        word_buf[run_len[BUF_IDX_W-1:0]] = c;
                    grow_run();
                    step_position();
                    return;
                end
                mode = M_IDLE;
                expect_token(word_kind(), run_len, INT_W'(0), 1'b0, 1'b0);
            end
            default:
                mode = M_IDLE;
        endcase

        token_origin = position;
        if (at_end)
        begin
            expect_token(K_EOF, LEN_W'(0), INT_W'(0), 1'b0, 1'b1);
            mode = M_DONE;
            return;
        end
        step_position();
        run_len = LEN_W'(1);
        is_punct = 1'b1;
        k = K_DOT;
        case (c)
            ".":     k = K_DOT;
            ",":     k = K_COMMA;
            ";":     k = K_SEMI;
            ":":     k = K_COLON;
            "+":     k = K_PLUS;
            "-":     k = K_MINUS;
            "*":     k = K_STAR;
            "#":     k = K_HASH;
            "(":     k = K_LPAREN;
            ")":     k = K_RPAREN;
            "{":     k = K_LBRACE;
            "}":     k = K_RBRACE;
            "[":     k = K_LBRACKET;
            "]":     k = K_RBRACKET;
            default: is_punct = 1'b0;
        endcase
        if (is_punct)
            expect_token(k, LEN_W'(1), INT_W'(0), 1'b0, 1'b0);
        else if (c == "=")
        begin
            held_kind = K_ASSIGN;
            held_pair = K_EQ_EQ;
            mode = M_OP;
        end
        else if (c == "!")
        begin
            held_kind = K_NOT;
            held_pair = K_NOT_EQ;
            mode = M_OP;
        end
        else if (c == "<")
        begin
            held_kind = K_LESS;
            held_pair = K_LESS_EQ;
            mode = M_OP;
        end
        else if (c == ">")
        begin
            held_kind = K_GREATER;
            held_pair = K_GREATER_EQ;
            mode = M_OP;
        end
        else if (c == "/")
            mode = M_SLASH;
        else if (c == QUOTE)
            mode = M_STRING;
        else if (c != " " && c != TAB && c != LF && c != CR)
        begin
            if (is_numeral(c))
            begin
                value_acc = INT_W'(c - "0");
                mode = M_NUMBER;
            end
            else
            begin
                word_buf[0] = c;
                mode = M_WORD;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        token_t want;
        if (!rst_n)
        begin
            mode = M_IDLE;
            held_kind = K_ASSIGN;
            held_pair = K_EQ_EQ;
            token_origin = '0;
            position = '0;
            value_acc = '0;
            run_len = '0;
            expected_tokens.delete();
            mismatches = 0;
            outstanding <= 0;
        end
        else
        begin
            if (src.valid && src.ready)
                scan_byte(src.ch, src.end_of_source);
            if (tok.valid && tok.ready)
            begin
                if (expected_tokens.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected token: kind %0d start %0d len %0d value %0d",
                                 tok.kind, tok.start_pos, tok.lexeme_len, tok.int_value);
                    mismatches++;
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    if (tok.kind !== want.kind || tok.start_pos !== want.start_pos ||
                        tok.lexeme_len !== want.lexeme_len ||
                        tok.int_value !== want.int_value ||
                        tok.string_error !== want.string_error || tok.last !== want.last)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("token mismatch (kind start len value err last)");
                            $display("  expected %0d %0d %0d %0d %0b %0b",
                                     want.kind, want.start_pos, want.lexeme_len,
                                     want.int_value, want.string_error, want.last);
                            $display("  actual   %0d %0d %0d %0d %0b %0b",
                                     tok.kind, tok.start_pos, tok.lexeme_len,
                                     tok.int_value, tok.string_error, tok.last);
                        end
                        mismatches++;
                    end
                end
            end
            outstanding <= expected_tokens.size();
        end
    end

endmodule

// File: tb/source_token_scanner_core_tb.sv
// ----------------------------------------------------------------------------
// Source token scanner testbench
// Feeds the scanner one source text: a short directed line with every
// punctuation mark and operator but a lone !, then about a thousand bytes of
// random keywords, words, numbers, strings, comments, operators and noise,
// and a randomly chosen unfinished tail closed by the end marker or NUL.
// Bytes offered after EOF must be ignored. The sender works in bursts, the
// receiver stalls on its own pattern and once holds off for a long stretch.
// ----------------------------------------------------------------------------
module source_token_scanner_core_tb;
    import stsc_pkg::*;

    localparam int POS_BITS      = 24;
    localparam int WORD_MAX      = 10;
    localparam int ITEM_TARGET   = 1100;
    localparam int HOLD_AT       = 400;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 32;
    localparam int CYCLE_LIMIT   = 200000;

    localparam logic [7:0] NUL   = 8'h00;
    localparam logic [7:0] TAB   = 8'h09;
    localparam logic [7:0] LF    = 8'h0A;
    localparam logic [7:0] CR    = 8'h0D;
    localparam logic [7:0] QUOTE = 8'h22;

    localparam string WORD_HEADS = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
    localparam string WORD_TAILS = "abcefilnoqrsvxzEFRZ_0123456789";
    localparam string DIGITS     = "0123456789";
    localparam string PUNCTS     = ".,;:+-*#(){}[]";

    typedef enum int {
        F_KEYWORD,
        F_WORD,
        F_ODD_WORD,
        F_NUMBER,
        F_STRING,
        F_COMMENT,
        F_OPERATOR,
        F_PUNCT,
        F_NOISE
    } fragment_t;

    logic       clk;
    logic       rst_n;
    logic       hold_off;
    int         mismatches;
    int         outstanding;
    int         beats_sent;
    int         burst_left;
    logic [7:0] text_q [$];
    logic [7:0] blanks [4] = '{8'h20, TAB, LF, CR};
    string      keywords [NUM_KW] = '{"escreveR", "var", "verdadeiro", "falso",
                                      "enquanto", "se", "senao", "fim"};
    string      operators [9] = '{"==", "!=", "<=", ">=", "=", "!", "<", ">", "/"};

    stsc_in_if  src ();
    stsc_out_if tok ();

    source_token_scanner_core #(
        .POS_BITS(POS_BITS),
        .KEYWORD_MAX_LEN(WORD_MAX)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in(src),
        .out(tok)
    );

    source_token_scanner_checker #(
        .POS_BITS(POS_BITS),
        .WORD_MAX(WORD_MAX)
    ) token_check (
        .clk(clk),
        .rst_n(rst_n),
        .src(src),
        .tok(tok),
        .mismatches(mismatches),
        .outstanding(outstanding)
    );

    function automatic logic [7:0] pick(input string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    task automatic append_text(input string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endtask

    task automatic add_fragment(input fragment_t choice);
        int         n;
        logic [7:0] c;
        case (choice)
            F_KEYWORD:
            begin
                append_text(keywords[$urandom_range(0, NUM_KW - 1)]);
                case ($urandom_range(0, 5))
                    0:       void'(text_q.pop_back());
                    1:       text_q.push_back(pick(WORD_TAILS));
                    default: ;
                endcase
            end
            F_WORD:
            begin
                n = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 6);
                text_q.push_back(pick(WORD_HEADS));
                repeat (n - 1) text_q.push_back(pick(WORD_TAILS));
            end
            F_ODD_WORD:
            begin
                case ($urandom_range(0, 3))
                    0:       c = 8'($urandom_range(128, 255));
                    1:       c = 8'($urandom_range(1, 8));
                    2:       c = 8'($urandom_range(14, 31));
                    default: c = pick("@$?~^&|%'\\");
                endcase
                text_q.push_back(c);
                repeat ($urandom_range(0, 4)) text_q.push_back(pick(WORD_TAILS));
            end
            F_NUMBER:
            begin
                case ($urandom_range(0, 5))
                    0:       append_text("2147483647");
                    1:       append_text("2147483648");
                    2:       append_text("99999999999999");
                    default: repeat ($urandom_range(1, 6)) text_q.push_back(pick(DIGITS));
                endcase
            end
            F_STRING:
            begin
                text_q.push_back(QUOTE);
                repeat ($urandom_range(0, 10))
                begin
                    do c = 8'($urandom_range(1, 255)); while (c == QUOTE);
                    text_q.push_back(c);
                end
                text_q.push_back(QUOTE);
            end
            F_COMMENT:
            begin
                append_text("//");
                repeat ($urandom_range(0, 8))
                begin
                    do c = 8'($urandom_range(1, 255)); while (c == LF || c == CR);
                    text_q.push_back(c);
                end
                text_q.push_back(($urandom_range(0, 1) == 1) ? LF : CR);
            end
            F_OPERATOR:
                append_text(operators[$urandom_range(0, 8)]);
            F_PUNCT:
                text_q.push_back(pick(PUNCTS));
            default:
                repeat ($urandom_range(1, 3)) text_q.push_back(8'($urandom_range(1, 255)));
        endcase
    endtask

    task automatic send_beat(input logic [7:0] c, input logic eos);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                src.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        src.valid <= 1'b1;
        src.ch <= c;
        src.end_of_source <= eos;
        do @(posedge clk); while (!src.ready);
    endtask

    task automatic send_text();
        while (text_q.size() > 0)
        begin
            send_beat(text_q.pop_front(), 1'b0);
            beats_sent++;
        end
    endtask

    task automatic wait_drained();
        src.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        bit held;
        int run;
        held = 1'b0;
        tok.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (hold_off && !held)
            begin
                held = 1'b1;
                tok.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                run = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 12);
                tok.ready <= 1'b1;
                repeat (run) @(posedge clk);
                if ($urandom_range(0, 2) != 0)
                begin
                    tok.ready <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(posedge clk);
                end
            end
        end
    end

    initial
    begin
        src.valid <= 1'b0;
        src.ch <= NUL;
        src.end_of_source <= 1'b0;
        hold_off <= 1'b0;
        rst_n <= 1'b0;
        beats_sent = 0;
        burst_left = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        append_text("(){}[].,;:+-*#==!=<=>=<>/=");
        text_q.push_back(8'hFF);
        append_text("9 ");
        send_text();
        wait_drained();

        while (beats_sent < ITEM_TARGET)
        begin
            if (beats_sent >= HOLD_AT)
                hold_off <= 1'b1;
            add_fragment(fragment_t'($urandom_range(0, int'(F_NOISE))));
            if ($urandom_range(0, 4) < 3)
                text_q.push_back(blanks[$urandom_range(0, 3)]);
            send_text();
            if ($urandom_range(0, 39) == 0)
                wait_drained();
        end

        // The source ends inside a string, a comment, an operator, a number,
        // a word or after a lone slash, so the end has to flush that state.
        case ($urandom_range(0, 5))
            0:
            begin
                add_fragment(F_STRING);
                void'(text_q.pop_back());
            end
            1:
            begin
                add_fragment(F_COMMENT);
                void'(text_q.pop_back());
            end
            2:       add_fragment(F_OPERATOR);
            3:       add_fragment(F_NUMBER);
            4:       add_fragment(F_KEYWORD);
            default: text_q.push_back("/");
        endcase
        send_text();
        if ($urandom_range(0, 1) == 1)
            send_beat(8'($urandom_range(0, 255)), 1'b1);
        else
            send_beat(NUL, 1'b0);
        repeat (4) send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
